// ===== hw/rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Request codes and item types shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef struct packed {
        t_req                      req_type;
        logic signed [VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic                      success;
        logic signed [VALUE_W-1:0] pop_value;
        logic [COUNT_W-1:0]        element_count;
    } t_out_item;

endpackage

// ===== hw/rtl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Single-port-write, single-port-read synchronous store with registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept in a circular synchronous store.
// A result strobes on o_done in the cycle after its item is accepted.
// Throughput: one item per cycle while o_busy is low; pointers and count update at accept and
// the store read lands in the following cycle.
// Reset: synchronous, active low; front pointer and count clear, store keeps
// its contents; o_busy is high for one cycle after reset.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dq_pkg::t_in_item   i_item,
    output logic               o_busy,
    output logic               o_done,
    output dq_pkg::t_out_item  o_result
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ready;
    logic             r_done;
    logic             r_ok;
    logic             r_pop;
    logic [CNT_W-1:0] r_res_count;

    logic             accept;
    logic             full, empty;
    logic [SUM_W-1:0] sum_back, sum_last;
    logic [IDX_W-1:0] pos_back, pos_last, front_dec, front_inc;
    logic             ok, is_pop;
    logic             we, re;
    logic [IDX_W-1:0] waddr, raddr;
    logic [dq_pkg::VALUE_W-1:0] rdata;

    assign accept = i_start & ~o_busy;
    assign full   = (r_count == DEPTH_C);
    assign empty  = (r_count == '0);

    assign sum_back = SUM_W'(r_front) + SUM_W'(r_count);
    assign sum_last = sum_back - SUM_W'(1);
    assign pos_back = (sum_back >= DEPTH_S) ? IDX_W'(sum_back - DEPTH_S) : IDX_W'(sum_back);
    assign pos_last = (sum_last >= DEPTH_S) ? IDX_W'(sum_last - DEPTH_S) : IDX_W'(sum_last);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + IDX_W'(1);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        ok      = 1'b0;
        is_pop  = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = pos_back;
        raddr   = r_front;
        case (i_item.req_type)
            dq_pkg::REQ_PUSH_FRONT: begin
                ok    = ~full;
                we    = accept & ~full;
                waddr = front_dec;
                if (we) begin
                    n_front = front_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            dq_pkg::REQ_PUSH_BACK: begin
                ok    = ~full;
                we    = accept & ~full;
                waddr = pos_back;
                if (we) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            dq_pkg::REQ_POP_FRONT: begin
                ok     = ~empty;
                is_pop = 1'b1;
                re     = accept & ~empty;
                raddr  = r_front;
                if (re) begin
                    n_front = front_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                ok     = ~empty;
                is_pop = 1'b1;
                re     = accept & ~empty;
                raddr  = pos_last;
                if (re) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        endcase
    end

    dq_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (dq_pkg::VALUE_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.push_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok        <= ok;
            r_pop       <= is_pop & ok;
            r_res_count <= n_count;
        end
    end

    assign o_busy                 = ~r_ready;
    assign o_done                 = r_done;
    assign o_result.success       = r_ok;
    assign o_result.pop_value     = r_pop ? rdata : '0;
    assign o_result.element_count = dq_pkg::COUNT_W'(r_res_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("element count above depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("result missing after accepted item");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.success) |-> (o_result.pop_value == '0))
        else $error("failed request returned a value");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ok) |=> (r_count != $past(r_count)))
        else $error("successful request left count unchanged");

endmodule

// ===== sim/dq_result_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dq_result_check
// Watches the request and result channels of the double-ended queue, keeps
// its own ring of entries to predict each result, and compares every result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dq_result_check #(
    parameter int unsigned DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  dq_pkg::t_in_item  i_item,
    input  logic              i_done,
    input  dq_pkg::t_out_item i_result,
    output int                o_fail_count,
    output int                o_pending
);

    logic [dq_pkg::VALUE_W-1:0] ring [DEPTH];
    int unsigned                head;
    int unsigned                fill;
    dq_pkg::t_out_item          expected_results [$];

    function automatic dq_pkg::t_out_item deque_apply(input dq_pkg::t_in_item req);
        dq_pkg::t_out_item res;
        int unsigned       slot;
        res = '0;
        case (req.req_type)
            dq_pkg::REQ_PUSH_FRONT: begin
                if (fill < DEPTH) begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = req.push_value;
                    fill++;
                    res.success = 1'b1;
                end
            end
            dq_pkg::REQ_PUSH_BACK: begin
                if (fill < DEPTH) begin
                    slot = (head + fill) % DEPTH;
                    ring[slot] = req.push_value;
                    fill++;
                    res.success = 1'b1;
                end
            end
            dq_pkg::REQ_POP_FRONT: begin
                if (fill > 0) begin
                    res.pop_value = ring[head];
                    head = (head + 1) % DEPTH;
                    fill--;
                    res.success = 1'b1;
                end
            end
            default: begin
                if (fill > 0) begin
                    slot = (head + fill - 1) % DEPTH;
                    res.pop_value = ring[slot];
                    fill--;
                    res.success = 1'b1;
                end
            end
        endcase
        res.element_count = dq_pkg::COUNT_W'(fill);
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        head = 0;
        fill = 0;
    end

    always @(posedge i_clk) begin
        dq_pkg::t_out_item want;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            expected_results.delete();
        end else begin
            if (i_start && !i_busy) begin
                expected_results.push_back(deque_apply(i_item));
            end
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.success !== want.success) begin
                        $error("success: expected %0b, got %0b",
                               want.success, i_result.success);
                        o_fail_count++;
                    end
                    if (i_result.pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, got %0d",
                               want.pop_value, i_result.pop_value);
                        o_fail_count++;
                    end
                    if (i_result.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, i_result.element_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push and pop requests into the double-ended queue: a directed run
// over empty, full and wrap cases, then random bursts that fill and drain
// the queue under several sender idle rates. Results are checked beside it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned DEPTH = 16;

    logic              clk;
    logic              rst_n;
    logic              start;
    dq_pkg::t_in_item  item;
    logic              busy;
    logic              done;
    dq_pkg::t_out_item result;
    int                fail_count;
    int                pending;
    int                idle_pct;

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_start  (start),
        .i_item   (item),
        .o_busy   (busy),
        .o_done   (done),
        .o_result (result)
    );

    dq_result_check #(.DEPTH(DEPTH)) u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_done       (done),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL double_ended_queue");
        $finish;
    end

    function automatic logic [dq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic dq_pkg::t_req pick_req(input int unsigned push_pct);
        logic to_back;
        to_back = 1'($urandom_range(1));
        if ($urandom_range(99) < push_pct) begin
            return to_back ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
        end
        return to_back ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input dq_pkg::t_req req,
                         input logic [dq_pkg::VALUE_W-1:0] value);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= '{req_type: req, push_value: value};
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // hold off until every outstanding item has its result
    task automatic settle();
        start <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial begin
        int          phase_pct [4];
        int unsigned burst_len;
        int unsigned push_pct;
        int unsigned sent;
        start    = 1'b0;
        item     = '0;
        rst_n    = 1'b0;
        idle_pct = 0;
        phase_pct = '{0, 77, 0, 18};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        issue(dq_pkg::REQ_POP_FRONT, 32'h1234_5678);
        issue(dq_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
        issue(dq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
        issue(dq_pkg::REQ_POP_BACK, 32'h0);
        issue(dq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
        issue(dq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        issue(dq_pkg::REQ_POP_FRONT, 32'h0);
        issue(dq_pkg::REQ_POP_FRONT, 32'h0);
        for (int i = 0; i < DEPTH; i++) begin
            issue(i[0] ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT, pick_value());
        end
        issue(dq_pkg::REQ_PUSH_FRONT, 32'h5A5A_5A5A);
        issue(dq_pkg::REQ_PUSH_BACK, 32'hA5A5_A5A5);
        settle();

        foreach (phase_pct[p]) begin
            idle_pct = phase_pct[p];
            sent = 0;
            while (sent < 450) begin
                burst_len = $urandom_range(4, 40);
                case ($urandom_range(2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
                repeat (burst_len) begin
                    issue(pick_req(push_pct), pick_value());
                end
                sent += burst_len;
                if ($urandom_range(9) == 0) begin
                    settle();
                end
            end
            settle();
        end

        repeat (5) @(negedge clk);
        if (fail_count == 0) begin
            $display("PASS double_ended_queue");
        end else begin
            $display("FAIL double_ended_queue");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/double_ended_queue.sv
sim/dq_result_check.sv
sim/tb_top.sv
